// File: rtl/core/srs_pkg.sv
// Shared types and constants of the SPI register slave block.
`timescale 1ns / 1ps

package srs_pkg;

    // Event codes carried in the operation field of an input beat.
    typedef enum logic [2:0] {
        OP_SELECT_LOW = 3'd0,
        OP_SPI_BYTE   = 3'd1,
        OP_SPI_DONE   = 3'd2,
        OP_TICK       = 3'd3,
        OP_POLL       = 3'd4,
        OP_UART_RX    = 3'd5,
        OP_UART_TX    = 3'd6
    } t_op;

    // Configuration register indexes.
    localparam logic CFG_BLINK_TICKS   = 1'b0;
    localparam logic CFG_TOGGLE_PERIOD = 1'b1;

    // Special frame addresses.
    localparam logic [7:0] ADDR_OUTPUT = 8'h08;
    localparam logic [7:0] ADDR_REPORT = 8'hFF;

    // Reset values.
    localparam logic [15:0] RESET_BLINK_TICKS   = 16'd100;
    localparam logic [7:0]  RESET_TOGGLE_PERIOD = 8'd25;
    localparam logic [15:0] STARTUP_BLINK_TICKS = 16'd500;

    localparam int unsigned FRAME_LEN = 2;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] blink_ticks;
        logic [7:0]  toggle_period;
    } t_led_cfg;

    // Result of the frame and register logic for one beat.
    typedef struct packed {
        logic        report_valid;
        logic [63:0] report_data;
        logic        report_pending;
        logic [4:0]  general_outputs;
    } t_frame_res;

endpackage

// File: rtl/core/srs_in_if.sv
// Input channel of the SPI register slave: one event per beat.
`timescale 1ns / 1ps

interface srs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// File: rtl/core/srs_out_if.sv
// Result channel of the SPI register slave: one result per beat.
`timescale 1ns / 1ps

interface srs_out_if;
    logic        valid;
    logic        ready;
    logic        report_valid;
    logic [63:0] report_data;
    logic        report_pending;
    logic [4:0]  general_outputs;
    logic        busy_led_level;
    logic        tx_led_level;
    logic        rx_led_level;

    modport source (
        output valid, output report_valid, output report_data, output report_pending,
        output general_outputs, output busy_led_level, output tx_led_level,
        output rx_led_level, input ready
    );
    modport sink (
        input valid, input report_valid, input report_data, input report_pending,
        input general_outputs, input busy_led_level, input tx_led_level,
        input rx_led_level, output ready
    );
endinterface

// File: rtl/core/spi_register_slave_with_leds.sv
// Top level of the SPI register slave with activity LEDs.
`timescale 1ns / 1ps

//  Channel   Direction  Beat contents
//  i_item    in         operation (3 bit event code), data_byte (SPI byte)
//  o_result  out        report_valid, report_data, report_pending,
//                       general_outputs, busy/tx/rx LED levels
//  i_cfg_*   in         write enable, register index, 16-bit write data
//
//  One beat can be taken in every cycle. An accepted beat sits in the input
//  register, is processed once the output register is free or draining, and its
//  result lands in the output register, from which the sink takes the result beat.
//  Reset is synchronous, active low; clears both valids, loads config, frame and LED state.
//  A stalled result holds the output register; the input register takes one
//  more beat, then i_item.ready drops until the result is taken.

module spi_register_slave_with_leds #(
    parameter int unsigned NUM_REPORT_REGS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srs_in_if.sink      i_item,
    srs_out_if.source   o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import srs_pkg::*;

    // Configuration registers.
    t_led_cfg r_cfg;

    // Input register: holds one accepted beat until it can be processed.
    logic  r_in_valid;
    t_item r_in_item;

    // Output register: holds one result until the sink takes it.
    logic        r_out_valid;
    t_frame_res  r_out_frame;
    logic [2:0]  r_out_levels;

    // A held beat is processed whenever the output register is free or draining.
    logic       process;
    t_frame_res frame_res;
    logic [2:0] led_levels;

    assign process      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_ticks   <= RESET_BLINK_TICKS;
            r_cfg.toggle_period <= RESET_TOGGLE_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLINK_TICKS:   r_cfg.blink_ticks   <= i_cfg_data;
                CFG_TOGGLE_PERIOD: r_cfg.toggle_period <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item.op        <= t_op'(i_item.operation);
            r_in_item.data_byte <= i_item.data_byte;
        end
    end

    srs_frame #(
        .NUM_REPORT_REGS(NUM_REPORT_REGS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_item  (r_in_item),
        .o_res   (frame_res)
    );

    srs_leds u_leds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (process),
        .i_op     (r_in_item.op),
        .i_cfg    (r_cfg),
        .o_levels (led_levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_frame  <= frame_res;
            r_out_levels <= led_levels;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.report_valid    = r_out_frame.report_valid;
    assign o_result.report_data     = r_out_frame.report_data;
    assign o_result.report_pending  = r_out_frame.report_pending;
    assign o_result.general_outputs = r_out_frame.general_outputs;
    assign o_result.busy_led_level  = r_out_levels[0];
    assign o_result.tx_led_level    = r_out_levels[1];
    assign o_result.rx_led_level    = r_out_levels[2];

`ifndef SYNTHESIS
    // A result without a report never carries report data.
    a_no_data_without_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_frame.report_valid |-> r_out_frame.report_data == 64'h0)
        else $error("report data set without a valid report");

    // A held beat that cannot be processed stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !process |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost or changed a stalled beat");

    // A processed poll always leaves the pending mark cleared.
    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in_item.op == OP_POLL |=> r_out_valid && !r_out_frame.report_pending)
        else $error("poll did not clear the pending mark");
`endif

endmodule

// File: rtl/core/srs_frame.sv
// SPI frame capture, report registers, general output register and pending mark.
`timescale 1ns / 1ps

module srs_frame #(
    parameter int unsigned NUM_REPORT_REGS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  srs_pkg::t_item     i_item,
    output srs_pkg::t_frame_res o_res
);
    import srs_pkg::*;

    localparam int unsigned IDX_W = (NUM_REPORT_REGS > 1) ? $clog2(NUM_REPORT_REGS) : 1;

    logic [1:0]  r_count, n_count;
    logic [7:0]  r_byte0, n_byte0;
    logic [7:0]  r_byte1, n_byte1;
    logic [7:0]  r_output, n_output;
    logic        r_pending, n_pending;
    logic [7:0]  r_regs [NUM_REPORT_REGS];
    logic        reg_we;
    logic [63:0] snapshot;
    logic        frame_full;

    for (genvar g = 0; g < 8; g++) begin : g_snap
        if (g < NUM_REPORT_REGS) begin : g_used
            assign snapshot[8*g +: 8] = r_regs[g];
        end else begin : g_unused
            assign snapshot[8*g +: 8] = 8'h00;
        end
    end

    assign frame_full = (r_count == 2'(FRAME_LEN));

    always_comb begin
        n_count   = r_count;
        n_byte0   = r_byte0;
        n_byte1   = r_byte1;
        n_output  = r_output;
        n_pending = r_pending;
        reg_we    = 1'b0;
        o_res.report_valid = 1'b0;
        o_res.report_data  = 64'h0;
        case (i_item.op)
            OP_SELECT_LOW: begin
                n_count = 2'd0;
            end
            OP_SPI_BYTE: begin
                if (r_count < 2'(FRAME_LEN)) begin
                    if (r_count[0]) begin
                        n_byte1 = i_item.data_byte;
                    end else begin
                        n_byte0 = i_item.data_byte;
                    end
                    n_count = r_count + 2'd1;
                end
            end
            OP_SPI_DONE: begin
                if (frame_full) begin
                    if (r_byte0 < 8'(NUM_REPORT_REGS)) begin
                        reg_we = 1'b1;
                    end else if (r_byte0 == ADDR_OUTPUT) begin
                        n_output = r_byte1;
                    end else if (r_byte0 == ADDR_REPORT) begin
                        n_pending = 1'b1;
                    end
                end
            end
            OP_POLL: begin
                if (r_pending) begin
                    o_res.report_valid = 1'b1;
                    o_res.report_data  = snapshot;
                    n_pending          = 1'b0;
                end
            end
            default: begin
            end
        endcase
        o_res.report_pending  = n_pending;
        o_res.general_outputs = n_output[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 2'd0;
            r_byte0   <= 8'h00;
            r_byte1   <= 8'h00;
            r_output  <= 8'h00;
            r_pending <= 1'b0;
            for (int i = 0; i < NUM_REPORT_REGS; i++) begin
                r_regs[i] <= 8'h00;
            end
        end else if (i_en) begin
            r_count   <= n_count;
            r_byte0   <= n_byte0;
            r_byte1   <= n_byte1;
            r_output  <= n_output;
            r_pending <= n_pending;
            if (reg_we) begin
                r_regs[r_byte0[IDX_W-1:0]] <= r_byte1;
            end
        end
    end

endmodule

// File: rtl/core/srs_leds.sv
// Activity blink counters, shared blink phase and active-low LED levels.
`timescale 1ns / 1ps

module srs_leds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  srs_pkg::t_op      i_op,
    input  srs_pkg::t_led_cfg i_cfg,
    output logic [2:0]        o_levels
);
    import srs_pkg::*;

    logic [15:0] r_busy_cnt, n_busy_cnt;
    logic [15:0] r_tx_cnt, n_tx_cnt;
    logic [15:0] r_rx_cnt, n_rx_cnt;
    logic        r_phase, n_phase;
    logic [7:0]  r_phase_ticks, n_phase_ticks;
    logic [2:0]  r_levels, n_levels;
    logic [7:0]  period;
    logic [8:0]  ticks_inc;

    assign period    = (i_cfg.toggle_period == 8'd0) ? 8'd1 : i_cfg.toggle_period;
    assign ticks_inc = {1'b0, r_phase_ticks} + 9'd1;

    always_comb begin
        n_busy_cnt    = r_busy_cnt;
        n_tx_cnt      = r_tx_cnt;
        n_rx_cnt      = r_rx_cnt;
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_levels      = r_levels;
        case (i_op)
            OP_SPI_BYTE: n_busy_cnt = i_cfg.blink_ticks;
            OP_UART_RX:  n_rx_cnt   = i_cfg.blink_ticks;
            OP_UART_TX:  n_tx_cnt   = i_cfg.blink_ticks;
            OP_TICK: begin
                // A running counter counts down and shows the phase; an idle LED is off.
                if (r_busy_cnt != 16'd0) begin
                    n_busy_cnt  = r_busy_cnt - 16'd1;
                    n_levels[0] = r_phase;
                end else begin
                    n_levels[0] = 1'b1;
                end
                if (r_tx_cnt != 16'd0) begin
                    n_tx_cnt    = r_tx_cnt - 16'd1;
                    n_levels[1] = r_phase;
                end else begin
                    n_levels[1] = 1'b1;
                end
                if (r_rx_cnt != 16'd0) begin
                    n_rx_cnt    = r_rx_cnt - 16'd1;
                    n_levels[2] = r_phase;
                end else begin
                    n_levels[2] = 1'b1;
                end
                if (r_phase_ticks == 8'd0) begin
                    n_phase = ~r_phase;
                end
                n_phase_ticks = (ticks_inc >= {1'b0, period}) ? 8'd0 : ticks_inc[7:0];
            end
            default: begin
            end
        endcase
    end

    assign o_levels = n_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt    <= STARTUP_BLINK_TICKS;
            r_tx_cnt      <= 16'd0;
            r_rx_cnt      <= 16'd0;
            r_phase       <= 1'b0;
            r_phase_ticks <= 8'd0;
            r_levels      <= 3'b111;
        end else if (i_en) begin
            r_busy_cnt    <= n_busy_cnt;
            r_tx_cnt      <= n_tx_cnt;
            r_rx_cnt      <= n_rx_cnt;
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_levels      <= n_levels;
        end
    end

endmodule
